[rtl/core/lerd_pkg.sv]
// Shared types and constants for the log entry record decoder.
package lerd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] TAG_NONE   = 3'd0;
    localparam logic [2:0] TAG_TYPE   = 3'd1;
    localparam logic [2:0] TAG_TERM   = 3'd2;
    localparam logic [2:0] TAG_INDEX  = 3'd3;
    localparam logic [2:0] TAG_LENGTH = 3'd4;

    localparam logic [1:0] MAX_ENTRY_TYPE = 2'd2;

    localparam logic [3:0] NARROW_VARINT_BYTES = 4'd5;
    localparam logic [3:0] WIDE_VARINT_BYTES   = 4'd10;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_TAG  = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE = 3'd2;
    localparam logic [2:0] ST_BAD_VINT = 3'd3;
    localparam logic [2:0] ST_BAD_LEN  = 3'd4;
    localparam logic [2:0] ST_TRAILING = 3'd5;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [1:0]  entry_type;
        logic [63:0] entry_term;
        logic [63:0] entry_index;
        logic [31:0] payload_length;
        logic [2:0]  status;
        logic        last;
    } res_t;

endpackage

[rtl/core/lerd_decode.sv]
// Record field decoder: parse state and per-byte next-state logic.
module lerd_decode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic [7:0]         byte_in,
    input  logic               byte_valid,
    input  logic               record_last,
    output logic [1:0]         res_count,
    output lerd_pkg::res_t     res_a,
    output lerd_pkg::res_t     res_b
);

    typedef enum logic [2:0] {
        PH_TAG,
        PH_VALUE,
        PH_PAYLOAD,
        PH_DONE,
        PH_ERROR
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  tag_reg, tag_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [1:0]  type_reg, type_next;
    logic [63:0] term_reg, term_next;
    logic [63:0] index_reg, index_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] remain_reg, remain_next;
    logic [2:0]  err_reg, err_next;

    logic [6:0]  shamt;
    logic [63:0] acc_fed;
    logic [3:0]  cnt_inc;
    logic        wide;
    logic        cont;
    logic        is_pay;
    logic [2:0]  sum_status;

    always_comb
    begin
        wide    = (phase_reg == PH_VALUE) && (tag_reg != lerd_pkg::TAG_TYPE);
        shamt   = 7'(cnt_reg) * 7'd7;
        acc_fed = acc_reg;
        if (!shamt[6])
        begin
            acc_fed = acc_reg | ({57'd0, byte_in[6:0]} << shamt[5:0]);
        end
        if (!wide)
        begin
            acc_fed = {32'd0, acc_fed[31:0]};
        end
        cnt_inc = cnt_reg + 4'd1;
        cont    = byte_in[7];
        is_pay  = byte_valid && (phase_reg == PH_PAYLOAD);

        phase_next  = phase_reg;
        tag_next    = tag_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        type_next   = type_reg;
        term_next   = term_reg;
        index_next  = index_reg;
        length_next = length_reg;
        remain_next = remain_reg;
        err_next    = err_reg;

        if (byte_valid)
        begin
            case (phase_reg)
                PH_TAG, PH_VALUE:
                begin
                    if (cont)
                    begin
                        if (cnt_inc >= (wide ? lerd_pkg::WIDE_VARINT_BYTES
                                             : lerd_pkg::NARROW_VARINT_BYTES))
                        begin
                            phase_next = PH_ERROR;
                            err_next   = lerd_pkg::ST_BAD_VINT;
                        end
                        else
                        begin
                            acc_next = acc_fed;
                            cnt_next = cnt_inc;
                        end
                    end
                    else
                    begin
                        acc_next = 64'd0;
                        cnt_next = 4'd0;
                        if (phase_reg == PH_TAG)
                        begin
                            if ((acc_fed[31:0] == 32'd0)
                                || (acc_fed[31:0] > 32'(lerd_pkg::TAG_LENGTH))
                                || (acc_fed[31:0] <= 32'(tag_reg)))
                            begin
                                phase_next = PH_ERROR;
                                err_next   = lerd_pkg::ST_BAD_TAG;
                            end
                            else
                            begin
                                tag_next   = acc_fed[2:0];
                                phase_next = PH_VALUE;
                            end
                        end
                        else
                        begin
                            case (tag_reg)
                                lerd_pkg::TAG_TYPE:
                                begin
                                    if (acc_fed[31:0] > 32'(lerd_pkg::MAX_ENTRY_TYPE))
                                    begin
                                        phase_next = PH_ERROR;
                                        err_next   = lerd_pkg::ST_BAD_TYPE;
                                    end
                                    else
                                    begin
                                        type_next  = acc_fed[1:0];
                                        phase_next = PH_TAG;
                                    end
                                end
                                lerd_pkg::TAG_TERM:
                                begin
                                    term_next  = acc_fed;
                                    phase_next = PH_TAG;
                                end
                                lerd_pkg::TAG_INDEX:
                                begin
                                    index_next = acc_fed;
                                    phase_next = PH_TAG;
                                end
                                default:
                                begin
                                    if (|acc_fed[63:32])
                                    begin
                                        phase_next = PH_ERROR;
                                        err_next   = lerd_pkg::ST_BAD_LEN;
                                    end
                                    else
                                    begin
                                        length_next = acc_fed[31:0];
                                        remain_next = acc_fed[31:0];
                                        phase_next  = (acc_fed[31:0] == 32'd0) ? PH_DONE
                                                                               : PH_PAYLOAD;
                                    end
                                end
                            endcase
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    remain_next = remain_reg - 32'd1;
                    if (remain_reg == 32'd1)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_ERROR;
                    err_next   = lerd_pkg::ST_TRAILING;
                end
                default:
                begin
                end
            endcase
        end

        if (phase_next == PH_ERROR)
        begin
            sum_status = err_next;
        end
        else if ((phase_next == PH_VALUE) || ((phase_next == PH_TAG) && (cnt_next != 4'd0)))
        begin
            sum_status = lerd_pkg::ST_BAD_VINT;
        end
        else if (phase_next == PH_PAYLOAD)
        begin
            sum_status = lerd_pkg::ST_BAD_LEN;
        end
        else
        begin
            sum_status = lerd_pkg::ST_OK;
        end

        res_b.kind           = lerd_pkg::KIND_SUMMARY;
        res_b.payload_byte   = 8'd0;
        res_b.entry_type     = type_next;
        res_b.entry_term     = term_next;
        res_b.entry_index    = index_next;
        res_b.payload_length = length_next;
        res_b.status         = sum_status;
        res_b.last           = 1'b1;

        if (is_pay)
        begin
            res_a.kind           = lerd_pkg::KIND_PAYLOAD;
            res_a.payload_byte   = byte_in;
            res_a.entry_type     = 2'd0;
            res_a.entry_term     = 64'd0;
            res_a.entry_index    = 64'd0;
            res_a.payload_length = 32'd0;
            res_a.status         = lerd_pkg::ST_OK;
            res_a.last           = !record_last;
        end
        else
        begin
            res_a = res_b;
        end

        res_count = {1'b0, is_pay} + {1'b0, record_last};

        // record end: back to the reset state
        if (record_last)
        begin
            phase_next  = PH_TAG;
            tag_next    = lerd_pkg::TAG_NONE;
            acc_next    = 64'd0;
            cnt_next    = 4'd0;
            type_next   = 2'd0;
            term_next   = 64'd0;
            index_next  = 64'd0;
            length_next = 32'd0;
            remain_next = 32'd0;
            err_next    = lerd_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TAG;
            tag_reg    <= lerd_pkg::TAG_NONE;
            acc_reg    <= 64'd0;
            cnt_reg    <= 4'd0;
            type_reg   <= 2'd0;
            term_reg   <= 64'd0;
            index_reg  <= 64'd0;
            length_reg <= 32'd0;
            remain_reg <= 32'd0;
            err_reg    <= lerd_pkg::ST_OK;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            tag_reg    <= tag_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            type_reg   <= type_next;
            term_reg   <= term_next;
            index_reg  <= index_next;
            length_reg <= length_next;
            remain_reg <= remain_next;
            err_reg    <= err_next;
        end
    end

endmodule

[rtl/core/lerd_rqueue.sv]
// Result queue: takes up to two results per cycle, drains one per cycle when popped.
module lerd_rqueue
#(
    parameter int DEPTH = lerd_pkg::QUEUE_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [1:0]                   push_cnt,
    input  lerd_pkg::res_t               push_a,
    input  lerd_pkg::res_t               push_b,
    input  logic                         pop,
    output lerd_pkg::res_t               head,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lerd_pkg::res_t mem [DEPTH];

    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] wr_ptr_b;

    always_comb
    begin
        wr_ptr_b    = wr_ptr_reg + AW'(1);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        wr_ptr_next = wr_ptr_reg + AW'(push_cnt);
        count_next  = count_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_a;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_b] <= push_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

[rtl/core/log_entry_record_decoder.sv]
// Top level of the log entry record decoder: input register, decoder, result queue.
//
// Input channel (in_valid/in_ready) carries one record byte per request:
// byte_in, byte_valid (0 for a request that carries no byte) and record_last.
// Output channel (out_valid/out_ready) carries results: result_kind 0 is a
// forwarded payload byte, 1 is the record summary (type, term, index,
// payload length, status). result_last marks the last result of a request.
// A request yields zero, one or two results.
// Results of a request go into the result queue in the cycle in which the
// request is taken from the input register; with the queue empty, the
// first result is at the output in the cycle after.
// Throughput: one request per cycle, as long as the result queue has room
// for its results; a request that gives two results fills two queue
// entries. The result queue (DEPTH entries, power of two, at least 2) sets
// how far the input runs ahead of a stalled output.
// Output stall: the queue fills, the input register holds its request and
// in_ready drops; nothing is lost.
// Reset (rst_n low, asynchronous): decoder returns to expecting a tag with
// all fields at their defaults, input register and queue empty.
module log_entry_record_decoder
#(
    parameter int DEPTH = lerd_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        byte_valid,
    input  logic        record_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [7:0]  payload_byte,
    output logic [1:0]  entry_type,
    output logic [63:0] entry_term,
    output logic [63:0] entry_index,
    output logic [31:0] payload_length,
    output logic [2:0]  status,
    output logic        result_last
);

    localparam int CW = $clog2(DEPTH + 1);

    logic        ireg_valid_reg;
    logic [7:0]  ireg_byte_reg;
    logic        ireg_bvalid_reg;
    logic        ireg_last_reg;

    logic           advance;
    logic [1:0]     need;
    logic [1:0]     push_cnt;
    logic [CW-1:0]  q_count;
    logic [CW-1:0]  q_free;
    logic           pop;
    lerd_pkg::res_t res_a;
    lerd_pkg::res_t res_b;
    lerd_pkg::res_t head;

    lerd_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .byte_in     (ireg_byte_reg),
        .byte_valid  (ireg_bvalid_reg),
        .record_last (ireg_last_reg),
        .res_count   (need),
        .res_a       (res_a),
        .res_b       (res_b)
    );

    lerd_rqueue #(.DEPTH(DEPTH)) u_rqueue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push_a   (res_a),
        .push_b   (res_b),
        .pop      (pop),
        .head     (head),
        .count    (q_count)
    );

    assign q_free   = CW'(DEPTH) - q_count;
    assign advance  = ireg_valid_reg && (CW'(need) <= q_free);
    assign push_cnt = advance ? need : 2'd0;
    assign in_ready = !ireg_valid_reg || advance;
    assign out_valid = (q_count != '0);
    assign pop      = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ireg_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            ireg_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ireg_byte_reg   <= byte_in;
            ireg_bvalid_reg <= byte_valid;
            ireg_last_reg   <= record_last;
        end
    end

    assign result_kind    = head.kind;
    assign payload_byte   = head.payload_byte;
    assign entry_type     = head.entry_type;
    assign entry_term     = head.entry_term;
    assign entry_index    = head.entry_index;
    assign payload_length = head.payload_length;
    assign status         = head.status;
    assign result_last    = head.last;

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CW'(DEPTH))
        else $error("result queue count beyond depth");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && ireg_last_reg |=> out_valid)
        else $error("record end produced no result");

    a_summary_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == lerd_pkg::KIND_SUMMARY) |-> result_last)
        else $error("summary result not marked last");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        ireg_valid_reg && !advance |=> ireg_valid_reg)
        else $error("stalled request dropped from input register");
`endif

endmodule

[tb/lerd_checker.sv]
// Scoreboard for the log entry record decoder: predicts results per request and compares them.
`timescale 1ns / 1ps

module lerd_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        byte_valid,
    input  logic        record_last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        result_kind,
    input  logic [7:0]  payload_byte,
    input  logic [1:0]  entry_type,
    input  logic [63:0] entry_term,
    input  logic [63:0] entry_index,
    input  logic [31:0] payload_length,
    input  logic [2:0]  status,
    input  logic        result_last,
    output int          mismatches,
    output int          outstanding,
    output int          matched
);

    typedef enum logic [2:0] {
        DEC_TAG,
        DEC_VALUE,
        DEC_PAYLOAD,
        DEC_DONE,
        DEC_FAILED
    } dec_phase_t;

    dec_phase_t      phase;
    logic [2:0]      prev_tag;
    logic [63:0]     acc;
    logic [3:0]      acc_bytes;
    logic [1:0]      type_q;
    logic [63:0]     term_q;
    logic [63:0]     index_q;
    logic [31:0]     length_q;
    logic [31:0]     remaining;
    logic [2:0]      err_code;
    lerd_pkg::res_t  expected_q[$];
    int              errors_seen;
    int              results_seen;

    function automatic void queue_result(lerd_pkg::res_t r);
        expected_q.insert(expected_q.size(), r);
    endfunction

    function automatic void clear_record();
        phase     = DEC_TAG;
        prev_tag  = lerd_pkg::TAG_NONE;
        acc       = '0;
        acc_bytes = '0;
        type_q    = '0;
        term_q    = '0;
        index_q   = '0;
        length_q  = '0;
        remaining = '0;
        err_code  = lerd_pkg::ST_OK;
    endfunction

    function automatic void latch_error(logic [2:0] code);
        phase    = DEC_FAILED;
        err_code = code;
    endfunction

    // 1: value complete, 0: more bytes follow, -1: too many bytes
    function automatic int feed_varint(logic [7:0] b, bit wide);
        int limit;
        limit = wide ? int'(lerd_pkg::WIDE_VARINT_BYTES) : int'(lerd_pkg::NARROW_VARINT_BYTES);
        if (7 * int'(acc_bytes) < 64)
            acc = acc | ({57'd0, b[6:0]} << (7 * int'(acc_bytes)));
        if (!wide)
            acc[63:32] = '0;
        acc_bytes = acc_bytes + 4'd1;
        if (b[7])
            return (int'(acc_bytes) >= limit) ? -1 : 0;
        return 1;
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        int          r;
        logic [63:0] v;
        case (phase)
            DEC_TAG:
            begin
                r = feed_varint(b, 1'b0);
                if (r < 0)
                    latch_error(lerd_pkg::ST_BAD_VINT);
                else if (r > 0)
                begin
                    v         = acc;
                    acc       = '0;
                    acc_bytes = '0;
                    if (v == 64'd0 || v > 64'(lerd_pkg::TAG_LENGTH) || v <= 64'(prev_tag))
                        latch_error(lerd_pkg::ST_BAD_TAG);
                    else
                    begin
                        prev_tag = v[2:0];
                        phase    = DEC_VALUE;
                    end
                end
            end
            DEC_VALUE:
            begin
                r = feed_varint(b, prev_tag != lerd_pkg::TAG_TYPE);
                if (r < 0)
                    latch_error(lerd_pkg::ST_BAD_VINT);
                else if (r > 0)
                begin
                    v         = acc;
                    acc       = '0;
                    acc_bytes = '0;
                    case (prev_tag)
                        lerd_pkg::TAG_TYPE:
                        begin
                            if (v > 64'(lerd_pkg::MAX_ENTRY_TYPE))
                                latch_error(lerd_pkg::ST_BAD_TYPE);
                            else
                            begin
                                type_q = v[1:0];
                                phase  = DEC_TAG;
                            end
                        end
                        lerd_pkg::TAG_TERM:
                        begin
                            term_q = v;
                            phase  = DEC_TAG;
                        end
                        lerd_pkg::TAG_INDEX:
                        begin
                            index_q = v;
                            phase   = DEC_TAG;
                        end
                        default:
                        begin
                            if (v > 64'hFFFF_FFFF)
                                latch_error(lerd_pkg::ST_BAD_LEN);
                            else
                            begin
                                length_q  = v[31:0];
                                remaining = v[31:0];
                                phase     = (v == 64'd0) ? DEC_DONE : DEC_PAYLOAD;
                            end
                        end
                    endcase
                end
            end
            DEC_PAYLOAD:
            begin
                remaining = remaining - 32'd1;
                if (remaining == 32'd0)
                    phase = DEC_DONE;
            end
            DEC_DONE:
                latch_error(lerd_pkg::ST_TRAILING);
            default:
                ;
        endcase
    endfunction

    function automatic void predict_request(logic [7:0] b, logic v, logic l);
        lerd_pkg::res_t r;
        logic           was_payload;
        if (v)
        begin
            was_payload = (phase == DEC_PAYLOAD);
            decode_byte(b);
            if (was_payload)
            begin
                r              = '0;
                r.kind         = lerd_pkg::KIND_PAYLOAD;
                r.payload_byte = b;
                r.last         = !l;
                queue_result(r);
            end
        end
        if (l)
        begin
            r                = '0;
            r.kind           = lerd_pkg::KIND_SUMMARY;
            r.entry_type     = type_q;
            r.entry_term     = term_q;
            r.entry_index    = index_q;
            r.payload_length = length_q;
            if (phase == DEC_FAILED)
                r.status = err_code;
            else if (phase == DEC_VALUE || (phase == DEC_TAG && acc_bytes != 4'd0))
                r.status = lerd_pkg::ST_BAD_VINT;
            else if (phase == DEC_PAYLOAD)
                r.status = lerd_pkg::ST_BAD_LEN;
            else
                r.status = lerd_pkg::ST_OK;
            r.last = 1'b1;
            queue_result(r);
            clear_record();
        end
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors_seen++;
        end
    endfunction

    function automatic void check_result();
        lerd_pkg::res_t want;
        if (expected_q.size() == 0)
        begin
            $error("result_kind: expected no result, actual %0b", result_kind);
            errors_seen++;
        end
        else
        begin
            want = expected_q.pop_front();
            results_seen++;
            compare_field("result_kind", 64'(want.kind), 64'(result_kind));
            compare_field("payload_byte", 64'(want.payload_byte), 64'(payload_byte));
            compare_field("entry_type", 64'(want.entry_type), 64'(entry_type));
            compare_field("entry_term", want.entry_term, entry_term);
            compare_field("entry_index", want.entry_index, entry_index);
            compare_field("payload_length", 64'(want.payload_length), 64'(payload_length));
            compare_field("status", 64'(want.status), 64'(status));
            compare_field("result_last", 64'(want.last), 64'(result_last));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_record();
            expected_q.delete();
            errors_seen  = 0;
            results_seen = 0;
            mismatches  <= 0;
            matched     <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                predict_request(byte_in, byte_valid, record_last);
            mismatches  <= errors_seen;
            matched     <= results_seen;
            outstanding <= expected_q.size();
        end
    end

endmodule

[tb/tb_log_entry_record_decoder.sv]
// Top of the log entry record decoder testbench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module tb_log_entry_record_decoder;

    localparam int CYCLE_LIMIT    = 500000;
    localparam int REQUEST_TARGET = 1500;
    localparam int LONG_HOLD      = 200;
    localparam int DRAIN_CYCLES   = 16;
    localparam int NARROW_BYTES   = int'(lerd_pkg::NARROW_VARINT_BYTES);
    localparam int WIDE_BYTES     = int'(lerd_pkg::WIDE_VARINT_BYTES);

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  byte_in;
    logic        byte_valid;
    logic        record_last;
    logic        out_valid;
    logic        out_ready;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [1:0]  entry_type;
    logic [63:0] entry_term;
    logic [63:0] entry_index;
    logic [31:0] payload_length;
    logic [2:0]  status;
    logic        result_last;

    int          mismatches;
    int          outstanding;
    int          matched;
    int          cycles = 0;
    int          requests_sent = 0;
    int          records_sent = 0;
    int          faulty_records = 0;
    bit          calm = 1'b0;
    bit          hold_off_req = 1'b0;
    logic [7:0]  rec_bytes[$];

    log_entry_record_decoder u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_in        (byte_in),
        .byte_valid     (byte_valid),
        .record_last    (record_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .payload_byte   (payload_byte),
        .entry_type     (entry_type),
        .entry_term     (entry_term),
        .entry_index    (entry_index),
        .payload_length (payload_length),
        .status         (status),
        .result_last    (result_last)
    );

    lerd_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_in        (byte_in),
        .byte_valid     (byte_valid),
        .record_last    (record_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .payload_byte   (payload_byte),
        .entry_type     (entry_type),
        .entry_term     (entry_term),
        .entry_index    (entry_index),
        .payload_length (payload_length),
        .status         (status),
        .result_last    (result_last),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .matched        (matched)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 6) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    function automatic void add_byte(logic [7:0] b);
        rec_bytes.insert(rec_bytes.size(), b);
    endfunction

    function automatic int varint_size(logic [63:0] v);
        int n;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 64'd0)
            n++;
        return n;
    endfunction

    // nbytes groups of 7 bits; continuation on all of them, or on all but the last if terminated
    function automatic void put_varint(logic [63:0] v, int nbytes, bit terminate);
        logic [7:0] b;
        for (int i = 0; i < nbytes; i++)
        begin
            b = 8'((v >> (7 * i)) & 64'h7F);
            if (i < nbytes - 1 || !terminate)
                b[7] = 1'b1;
            add_byte(b);
        end
    endfunction

    // sometimes padded encodings, sometimes junk above the field width
    function automatic void put_value(logic [63:0] v, int maxb);
        int         nb;
        logic [6:0] junk;
        nb = varint_size(v);
        if (nb < maxb && $urandom_range(0, 7) == 0)
            nb = $urandom_range(nb, maxb);
        put_varint(v, nb, 1'b1);
        if (nb == maxb && $urandom_range(0, 1) == 0)
        begin
            junk = 7'($urandom);
            junk = junk & ((maxb == WIDE_BYTES) ? 7'h7E : 7'h70);
            rec_bytes[rec_bytes.size() - 1] = rec_bytes[rec_bytes.size() - 1] | {1'b0, junk};
        end
    endfunction

    function automatic void put_noise(int n);
        repeat (n) add_byte(8'($urandom));
    endfunction

    function automatic logic [63:0] rand_magnitude();
        case ($urandom_range(0, 15))
            0: return '1;
            1: return '0;
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    function automatic void put_fields(logic [3:0] mask, int max_len);
        int len;
        if (mask[0])
        begin
            put_value(64'(lerd_pkg::TAG_TYPE), NARROW_BYTES);
            put_value(64'($urandom_range(0, int'(lerd_pkg::MAX_ENTRY_TYPE))), NARROW_BYTES);
        end
        if (mask[1])
        begin
            put_value(64'(lerd_pkg::TAG_TERM), NARROW_BYTES);
            put_value(rand_magnitude(), WIDE_BYTES);
        end
        if (mask[2])
        begin
            put_value(64'(lerd_pkg::TAG_INDEX), NARROW_BYTES);
            put_value(rand_magnitude(), WIDE_BYTES);
        end
        if (mask[3])
        begin
            len = $urandom_range(0, max_len);
            put_value(64'(lerd_pkg::TAG_LENGTH), NARROW_BYTES);
            put_value(64'(len), WIDE_BYTES);
            put_noise(len);
        end
    endfunction

    task automatic send_item(logic [7:0] b, logic v, logic l);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        byte_in     <= b;
        byte_valid  <= v;
        record_last <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (v || l)
            requests_sent++;
    endtask

    // marker_end closes the record with a request that carries no byte
    task automatic send_record(bit marker_end);
        int n;
        n = rec_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(rec_bytes[i], 1'b1, !marker_end && i == n - 1);
        end
        if (marker_end || n == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
        rec_bytes.delete();
        records_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int          flavor;
        int          cut;
        logic [3:0]  mask;
        logic [63:0] v;
        bit          marker;
        bit          hold_done;
        bit          pause_done;

        hold_done   = 1'b0;
        pause_done  = 1'b0;
        in_valid    <= 1'b0;
        byte_in     <= '0;
        byte_valid  <= 1'b0;
        record_last <= 1'b0;
        rst_n       <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        calm = 1'b1;
        send_record(1'b1);
        send_item(8'hA5, 1'b0, 1'b0);
        put_varint(64'(lerd_pkg::TAG_TYPE), 1, 1'b1);
        put_varint(64'(lerd_pkg::MAX_ENTRY_TYPE), 1, 1'b1);
        send_record(1'b0);
        put_varint(64'(lerd_pkg::TAG_TERM), 1, 1'b1);
        put_varint('1, WIDE_BYTES, 1'b1);
        send_record(1'b0);
        put_varint(64'(lerd_pkg::TAG_TYPE), 1, 1'b1);
        put_varint(64'd3, 1, 1'b1);
        send_record(1'b0);
        put_varint(64'(lerd_pkg::TAG_NONE), 1, 1'b1);
        send_record(1'b0);
        put_varint(64'd5, 1, 1'b1);
        send_record(1'b0);
        put_varint(64'(lerd_pkg::TAG_INDEX), 1, 1'b1);
        put_varint(64'd0, 1, 1'b1);
        put_varint(64'(lerd_pkg::TAG_TERM), 1, 1'b1);
        put_varint(64'd0, 1, 1'b1);
        send_record(1'b0);
        put_varint(64'd0, NARROW_BYTES, 1'b0);
        send_record(1'b0);
        put_varint(64'(lerd_pkg::TAG_TERM), 1, 1'b0);
        send_record(1'b0);
        put_varint(64'(lerd_pkg::TAG_TERM), 1, 1'b1);
        send_record(1'b0);
        put_varint(64'(lerd_pkg::TAG_LENGTH), 1, 1'b1);
        put_varint(64'h1_0000_0000, 5, 1'b1);
        send_record(1'b0);
        put_varint(64'(lerd_pkg::TAG_LENGTH), 1, 1'b1);
        put_varint(64'hFFFF_FFFF, 5, 1'b1);
        put_noise(1);
        send_record(1'b0);
        put_varint(64'(lerd_pkg::TAG_LENGTH), 1, 1'b1);
        put_varint(64'd2, 1, 1'b1);
        add_byte(8'h00);
        add_byte(8'hFF);
        send_record(1'b1);
        put_varint(64'(lerd_pkg::TAG_LENGTH), 1, 1'b1);
        put_varint(64'd0, 1, 1'b1);
        put_noise(1);
        send_record(1'b0);
        calm = 1'b0;

        while (requests_sent < REQUEST_TARGET)
        begin
            if (!hold_done && requests_sent >= 500)
            begin
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pause_done && requests_sent >= 900)
            begin
                wait_drained();
                pause_done = 1'b1;
            end
            calm   = (requests_sent >= 1300);
            mask   = 4'($urandom);
            marker = ($urandom_range(0, 7) == 0);
            flavor = $urandom_range(0, 15);
            if (flavor > 8)
                faulty_records++;
            case (flavor)
                9:
                begin
                    put_fields(mask | 4'b1000, 8);
                    cut = $urandom_range(1, rec_bytes.size());
                    repeat (cut) void'(rec_bytes.pop_back());
                end
                10:
                begin
                    put_fields(mask & 4'b0111, 0);
                    case ($urandom_range(0, 2))
                        0: v = 64'(lerd_pkg::TAG_NONE);
                        1: v = 64'($urandom_range(5, 2000));
                        default: v = mask[2] ? 64'(lerd_pkg::TAG_INDEX)
                                   : mask[1] ? 64'(lerd_pkg::TAG_TERM)
                                   : 64'(lerd_pkg::TAG_TYPE);
                    endcase
                    put_value(v, NARROW_BYTES);
                    put_noise($urandom_range(0, 4));
                end
                11:
                begin
                    case ($urandom_range(0, 2))
                        0:
                            put_varint(rand_magnitude(), NARROW_BYTES, 1'b0);
                        1:
                        begin
                            put_value(64'(lerd_pkg::TAG_TYPE), NARROW_BYTES);
                            put_varint(rand_magnitude(), NARROW_BYTES, 1'b0);
                        end
                        default:
                        begin
                            put_value(64'($urandom_range(int'(lerd_pkg::TAG_TERM),
                                                         int'(lerd_pkg::TAG_LENGTH))),
                                      NARROW_BYTES);
                            put_varint(rand_magnitude(), WIDE_BYTES, 1'b0);
                        end
                    endcase
                    put_noise($urandom_range(0, 3));
                end
                12:
                begin
                    put_value(64'(lerd_pkg::TAG_TYPE), NARROW_BYTES);
                    put_value(64'($urandom_range(3, 70000)), NARROW_BYTES);
                    put_fields(mask & 4'b1110, 4);
                end
                13:
                begin
                    put_fields(mask & 4'b0111, 0);
                    v = rand_magnitude() | (64'h1_0000_0000 << $urandom_range(0, 31));
                    put_value(64'(lerd_pkg::TAG_LENGTH), NARROW_BYTES);
                    put_value(v, WIDE_BYTES);
                    put_noise($urandom_range(0, 3));
                end
                14:
                begin
                    put_fields(mask | 4'b1000, 6);
                    put_noise($urandom_range(1, 3));
                end
                15:
                    put_noise($urandom_range(1, 12));
                default:
                    put_fields(mask, ($urandom_range(0, 7) == 0) ? 40 : 6);
            endcase
            send_record(marker);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests in %0d records, %0d records built with faults",
                 requests_sent, records_sent, faulty_records);
        $display("Compared %0d results, %0d field mismatches", matched, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/lerd_pkg.sv
rtl/core/lerd_decode.sv
rtl/core/lerd_rqueue.sv
rtl/core/log_entry_record_decoder.sv
tb/lerd_checker.sv
tb/tb_log_entry_record_decoder.sv
